### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Delayed implication, disabled while reset is asserted.
`define ASSERT_LAT2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/ico_pkg.sv
// ---------------------------------------------------------------------------
// ico_pkg
// Types, widths and icosahedron face tables for the triangle indexer.
// ---------------------------------------------------------------------------
package ico_pkg;

    localparam int CORNER_COUNT = 12;
    localparam int EDGE_COUNT   = 30;
    localparam int FACE_COUNT   = 20;

    localparam int N_W     = 7;   // subdivision register width
    localparam int COORD_W = 7;   // lattice coordinate, holds up to the subdivision
    localparam int FACE_W  = 5;
    localparam int IDX_W   = 16;  // node indices wrap to this width
    localparam int TRI_W   = 13;  // interior node count of one face

    // Configuration register indexes.
    localparam logic REG_SUBDIVISION = 1'b0;
    localparam logic REG_FLIP        = 1'b1;

    // Corner slot names within a face.
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] i;
        logic [COORD_W-1:0] j;
    } ico_point_t;

    typedef logic [3:0] corner_id_t;
    typedef logic [4:0] edge_id_t;

    localparam corner_id_t FACE_CORNER [FACE_COUNT][3] = '{
        '{4'd0, 4'd1, 4'd2},  '{4'd0, 4'd2, 4'd3},  '{4'd0, 4'd3, 4'd4},
        '{4'd0, 4'd4, 4'd5},  '{4'd0, 4'd5, 4'd1},  '{4'd1, 4'd6, 4'd2},
        '{4'd2, 4'd6, 4'd7},  '{4'd2, 4'd7, 4'd3},  '{4'd3, 4'd7, 4'd8},
        '{4'd3, 4'd8, 4'd4},  '{4'd4, 4'd8, 4'd9},  '{4'd4, 4'd9, 4'd5},
        '{4'd5, 4'd9, 4'd10}, '{4'd5, 4'd10, 4'd1}, '{4'd1, 4'd10, 4'd6},
        '{4'd6, 4'd11, 4'd7}, '{4'd7, 4'd11, 4'd8}, '{4'd8, 4'd11, 4'd9},
        '{4'd9, 4'd11, 4'd10}, '{4'd10, 4'd11, 4'd6}
    };

    localparam edge_id_t FACE_EDGE [FACE_COUNT][3] = '{
        '{5'd0, 5'd2, 5'd1},    '{5'd2, 5'd4, 5'd3},    '{5'd4, 5'd6, 5'd5},
        '{5'd6, 5'd8, 5'd7},    '{5'd8, 5'd0, 5'd9},    '{5'd10, 5'd1, 5'd11},
        '{5'd11, 5'd13, 5'd12}, '{5'd13, 5'd3, 5'd14},  '{5'd14, 5'd16, 5'd15},
        '{5'd16, 5'd5, 5'd17},  '{5'd17, 5'd19, 5'd18}, '{5'd19, 5'd7, 5'd20},
        '{5'd20, 5'd22, 5'd21}, '{5'd22, 5'd9, 5'd23},  '{5'd23, 5'd10, 5'd24},
        '{5'd25, 5'd12, 5'd26}, '{5'd26, 5'd15, 5'd27}, '{5'd27, 5'd18, 5'd28},
        '{5'd28, 5'd21, 5'd29}, '{5'd29, 5'd24, 5'd25}
    };

    // Set where the face walks that edge backward.
    localparam logic FACE_EDGE_REV [FACE_COUNT][3] = '{
        '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b1}
    };

endpackage

### hw/rtl/ico_node.sv
// ---------------------------------------------------------------------------
// ico_node
// Global node index of one lattice point of a face: corner, edge interior
// node or face interior node.
// ---------------------------------------------------------------------------
module ico_node
    import ico_pkg::*;
(
    input  logic [FACE_W-1:0] face,        // already limited to a legal face
    input  ico_point_t        point,
    input  logic [N_W-1:0]    subdivision,
    input  logic [IDX_W-1:0]  face_base,   // index one past this face's last interior node
    output logic [IDX_W-1:0]  node
);

    logic [N_W-1:0]     n_minus_1;
    logic [1:0]         slot;
    logic [COORD_W-1:0] k;
    edge_id_t           edge_id;
    logic               edge_rev;
    logic [11:0]        edge_prod;
    logic [COORD_W-1:0] edge_off;
    logic [IDX_W-1:0]   edge_node;
    logic [COORD_W-1:0] rows_left;
    logic [13:0]        tri_prod;
    logic [IDX_W-1:0]   inner_node;
    logic [COORD_W-1:0] right_j;

    assign n_minus_1 = subdivision - N_W'(1);
    assign rows_left = subdivision - point.i;
    assign right_j   = subdivision - point.i;

    // Pick the face edge that the point lies on, and its position k along it.
    always_comb
    begin
        if (point.i == '0)
        begin
            slot = SLOT_FIRST;
            k    = point.j;
        end
        else if (point.j == '0)
        begin
            slot = SLOT_SECOND;
            k    = point.i;
        end
        else
        begin
            slot = SLOT_THIRD;
            k    = point.i;
        end
    end

    assign edge_id   = FACE_EDGE[face][slot];
    assign edge_rev  = FACE_EDGE_REV[face][slot];
    assign edge_prod = {7'b0, edge_id} * {5'b0, n_minus_1};
    assign edge_off  = edge_rev ? (subdivision - k - COORD_W'(1)) : (k - COORD_W'(1));
    assign edge_node = IDX_W'(CORNER_COUNT) + {4'b0, edge_prod} + {9'b0, edge_off};

    // Nodes left below row i form a triangle of rows_left*(rows_left-1)/2 points.
    assign tri_prod   = {7'b0, rows_left} * {7'b0, rows_left - COORD_W'(1)};
    assign inner_node = face_base - {3'b0, tri_prod[13:1]} + {9'b0, point.j} - IDX_W'(1);

    always_comb
    begin
        if (point.i == '0 && point.j == '0)
            node = {12'b0, FACE_CORNER[face][SLOT_FIRST]};
        else if (point.i == '0 && point.j == subdivision)
            node = {12'b0, FACE_CORNER[face][SLOT_SECOND]};
        else if (point.i == '0)
            node = edge_node;
        else if (point.i == subdivision)
            node = {12'b0, FACE_CORNER[face][SLOT_THIRD]};
        else if (point.j == '0 || point.j == right_j)
            node = edge_node;
        else
            node = inner_node;
    end

endmodule

### hw/rtl/icosphere_triangle_indexer_top.sv
// ---------------------------------------------------------------------------
// icosphere_triangle_indexer_top
// Global node indices of one small triangle on a subdivided icosahedron.
// ---------------------------------------------------------------------------
// Usage:
//   Input transaction: drive face, row, column and kind and raise start; the
//   transaction is taken at every rising edge with start high, since busy
//   stays low. One transaction may be issued in every cycle.
//   Result transaction: done rises once the input register and the result
//   register have taken the transaction, and stays high for exactly one cycle
//   with vertex_first, vertex_second, vertex_third and invalid; the result is
//   taken at the rising edge that ends that cycle. An out-of-face position, an
//   illegal face or an illegal subdivision gives invalid high and zero vertices.
//   Throughput is one triangle per cycle; the input register and the result
//   register lie around the index logic.
//   Configuration: cfg_we with cfg_index and cfg_data writes subdivision or
//   flip_winding; write only while no transaction is in flight. Derived face
//   constants are registered from the subdivision register, and a start
//   issued in the cycle after a write already sees them.
//   Reset clears all control state; subdivision returns to 1 and
//   flip_winding to 0. The receiver cannot stall the result strobe.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module icosphere_triangle_indexer_top
    import ico_pkg::*;
#(
    parameter int MAX_SUBDIV = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [N_W-1:0]      cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [FACE_W-1:0]   face,
    input  logic [5:0]          row,
    input  logic [5:0]          column,
    input  logic                kind,
    output logic                done,
    output logic [IDX_W-1:0]    vertex_first,
    output logic [IDX_W-1:0]    vertex_second,
    output logic [IDX_W-1:0]    vertex_third,
    output logic                invalid
);

    localparam logic [8:0] MAX_N = 9'(MAX_SUBDIV);

    logic [N_W-1:0]    subdivision_reg;
    logic              flip_reg;
    logic [TRI_W-1:0]  tri_reg;
    logic [TRI_W-1:0]  tri_next;
    logic [IDX_W-1:0]  base_reg;
    logic [IDX_W-1:0]  base_next;
    logic [N_W-1:0]    n_minus_1;
    logic [N_W-1:0]    n_minus_2;
    logic [13:0]       tri_prod;
    logic [11:0]       edge_span;

    logic              in_valid_reg;
    logic [FACE_W-1:0] face_reg;
    logic [5:0]        row_reg;
    logic [5:0]        column_reg;
    logic              kind_reg;

    logic              done_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [IDX_W-1:0]  second_reg;
    logic [IDX_W-1:0]  third_reg;
    logic              invalid_reg;

    logic [FACE_W-1:0] face_sel;
    logic [17:0]       face_prod;
    logic [IDX_W-1:0]  face_base;
    logic [COORD_W-1:0] pos_i;
    logic [COORD_W-1:0] pos_j;
    logic              bad;
    ico_point_t        pt_a;
    ico_point_t        pt_b;
    ico_point_t        pt_c;
    logic [IDX_W-1:0]  node_a;
    logic [IDX_W-1:0]  node_b;
    logic [IDX_W-1:0]  node_c;

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subdivision_reg <= N_W'(1);
            flip_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SUBDIVISION: subdivision_reg <= cfg_data;
                REG_FLIP:        flip_reg        <= cfg_data[0];
            endcase
        end
    end

    // Per-subdivision constants: interior nodes per face, and the index one
    // past face 0's last interior node.
    assign n_minus_1 = subdivision_reg - N_W'(1);
    assign n_minus_2 = subdivision_reg - N_W'(2);
    assign tri_prod  = {7'b0, n_minus_1} * {7'b0, n_minus_2};
    assign tri_next  = tri_prod[13:1];
    assign edge_span = {5'b0, n_minus_1} * 12'(EDGE_COUNT);
    assign base_next = IDX_W'(CORNER_COUNT) + {4'b0, edge_span} + {3'b0, tri_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_reg  <= '0;
            base_reg <= IDX_W'(CORNER_COUNT);
        end
        else
        begin
            tri_reg  <= tri_next;
            base_reg <= base_next;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            face_reg   <= face;
            row_reg    <= row;
            column_reg <= column;
            kind_reg   <= kind;
        end
    end

    // Position check.
    assign pos_i = {1'b0, row_reg};
    assign pos_j = {1'b0, column_reg};

    always_comb
    begin
        bad = 1'b0;
        if (subdivision_reg == '0 || {2'b0, subdivision_reg} > MAX_N
            || face_reg >= FACE_W'(FACE_COUNT))
            bad = 1'b1;
        else if (pos_i >= subdivision_reg || pos_j >= (subdivision_reg - pos_i))
            bad = 1'b1;
        else if (kind_reg && pos_i == '0)
            bad = 1'b1;
    end

    assign face_sel  = (face_reg < FACE_W'(FACE_COUNT)) ? face_reg : '0;
    assign face_prod = {13'b0, face_sel} * {5'b0, tri_reg};
    assign face_base = base_reg + face_prod[IDX_W-1:0];

    // Triangle corners on the face lattice.
    always_comb
    begin
        pt_a.i = pos_i;
        pt_a.j = pos_j;
        if (!kind_reg)
        begin
            pt_b.i = pos_i;
            pt_b.j = pos_j + COORD_W'(1);
            pt_c.i = pos_i + COORD_W'(1);
            pt_c.j = pos_j;
        end
        else
        begin
            pt_b.i = pos_i - COORD_W'(1);
            pt_b.j = pos_j + COORD_W'(1);
            pt_c.i = pos_i;
            pt_c.j = pos_j + COORD_W'(1);
        end
    end

    ico_node u_node_a (
        .face        (face_sel),
        .point       (pt_a),
        .subdivision (subdivision_reg),
        .face_base   (face_base),
        .node        (node_a)
    );

    ico_node u_node_b (
        .face        (face_sel),
        .point       (pt_b),
        .subdivision (subdivision_reg),
        .face_base   (face_base),
        .node        (node_b)
    );

    ico_node u_node_c (
        .face        (face_sel),
        .point       (pt_c),
        .subdivision (subdivision_reg),
        .face_base   (face_base),
        .node        (node_c)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            invalid_reg <= bad;
            if (bad)
            begin
                first_reg  <= '0;
                second_reg <= '0;
                third_reg  <= '0;
            end
            else
            begin
                first_reg  <= node_a;
                second_reg <= flip_reg ? node_c : node_b;
                third_reg  <= flip_reg ? node_b : node_c;
            end
        end
    end

    assign done          = done_reg;
    assign vertex_first  = first_reg;
    assign vertex_second = second_reg;
    assign vertex_third  = third_reg;
    assign invalid       = invalid_reg;

    `ASSERT_LAT2(a_result_follows_start, start && !busy, done)
    `ASSERT_IMPL(a_no_spurious_result, done, $past(start && !busy, 2))
    `ASSERT_IMPL(a_invalid_zero, done && invalid,
                 vertex_first == '0 && vertex_second == '0 && vertex_third == '0)

endmodule
